// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands; clocked on i_clk, held off during i_rst_n low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define AST_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Check that the expression is never true.
`define AST_NEVER(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("forbidden condition seen");

`endif

// ===== sv/rtpe_pkg.sv =====
// ----------------------------------------------------------------------------
// rtpe_pkg
// Types, character codes, register name table and encoder helpers for the
// R-type operand parser.
// ----------------------------------------------------------------------------
package rtpe_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       line_start;
        logic [2:0] operation;
    } t_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] instr_word;
        logic [4:0]  dest_reg;
        logic [4:0]  src1_reg;
        logic [4:0]  src2_reg;
    } t_result;

    typedef struct packed {
        logic       hit;
        logic [4:0] num;
    } t_lookup;

    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_TOK1  = 7'b0000010,
        PH_GAP1  = 7'b0000100,
        PH_TOK2  = 7'b0001000,
        PH_GAP2  = 7'b0010000,
        PH_TOK3  = 7'b0100000,
        PH_TRAIL = 7'b1000000
    } t_phase;

    localparam logic [1:0] ST_FAIL = 2'd0;
    localparam logic [1:0] ST_OK   = 2'd1;
    localparam logic [1:0] ST_NUL  = 2'd2;
    localparam logic [1:0] ST_CMT  = 2'd3;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_XOR = 3'd2;
    localparam logic [2:0] OP_OR  = 3'd3;
    localparam logic [2:0] OP_AND = 3'd4;
    localparam logic [2:0] OP_SLL = 3'd5;
    localparam logic [2:0] OP_SRL = 3'd6;
    localparam logic [2:0] OP_SRA = 3'd7;

    localparam logic [6:0] OPC_OP   = 7'b0110011;
    localparam logic [6:0] F7_BASE  = 7'b0000000;
    localparam logic [6:0] F7_ALT   = 7'b0100000;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_SEMI  = 8'h3b;
    localparam logic [7:0] CH_EOF   = 8'hff;
    localparam logic [7:0] CH_X     = 8'h78;

    // Token bytes packed first byte lowest, unused bytes zero.
    localparam logic [31:0] NAME_ZERO = 32'h6f72657a;
    localparam logic [31:0] NAME_FP   = 32'h00007066;

    localparam logic [31:0] ABI_NAMES [32] = '{
        32'h6f72657a, 32'h00006172, 32'h00007073, 32'h00007067,
        32'h00007074, 32'h00003074, 32'h00003174, 32'h00003274,
        32'h00003073, 32'h00003173, 32'h00003061, 32'h00003161,
        32'h00003261, 32'h00003361, 32'h00003461, 32'h00003561,
        32'h00003661, 32'h00003761, 32'h00003273, 32'h00003373,
        32'h00003473, 32'h00003573, 32'h00003673, 32'h00003773,
        32'h00003873, 32'h00003973, 32'h00303173, 32'h00313173,
        32'h00003374, 32'h00003474, 32'h00003574, 32'h00003674
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // Map a held token to a register number.
    function automatic t_lookup reg_lookup(input logic [31:0] tok);
        t_lookup    res;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [5:0] two;
        b0  = tok[7:0];
        b1  = tok[15:8];
        b2  = tok[23:16];
        b3  = tok[31:24];
        two = 6'(b1[1:0]) * 6'd10 + 6'(b2[3:0]);
        res = '0;
        for (int i = 31; i >= 0; i--) begin
            if (tok == ABI_NAMES[i]) begin
                res.hit = 1'b1;
                res.num = 5'(i);
            end
        end
        if (!res.hit) begin
            if (tok == NAME_FP) begin
                res.hit = 1'b1;
                res.num = 5'd8;
            end else if (b0 == CH_X && is_digit(b1) && b2 == 8'h00 && b3 == 8'h00) begin
                res.hit = 1'b1;
                res.num = 5'(b1[3:0]);
            end else if (b0 == CH_X && b1 >= 8'h31 && b1 <= 8'h33 && is_digit(b2)
                         && b3 == 8'h00 && two <= 6'd31) begin
                res.hit = 1'b1;
                res.num = two[4:0];
            end
        end
        return res;
    endfunction

    function automatic logic [2:0] funct3_of(input logic [2:0] op);
        logic [2:0] f;
        case (op)
            OP_ADD:  f = 3'd0;
            OP_SUB:  f = 3'd0;
            OP_XOR:  f = 3'd4;
            OP_OR:   f = 3'd6;
            OP_AND:  f = 3'd7;
            OP_SLL:  f = 3'd1;
            OP_SRL:  f = 3'd5;
            OP_SRA:  f = 3'd5;
            default: f = 3'd0;
        endcase
        return f;
    endfunction

    function automatic logic [6:0] funct7_of(input logic [2:0] op);
        logic [6:0] f;
        case (op)
            OP_SUB:  f = F7_ALT;
            OP_SRA:  f = F7_ALT;
            default: f = F7_BASE;
        endcase
        return f;
    endfunction

    function automatic logic [31:0] encode_word(input logic [2:0] op, input logic [4:0] rd,
                                                input logic [4:0] rs1, input logic [4:0] rs2);
        return {funct7_of(op), rs2, rs1, funct3_of(op), rd, OPC_OP};
    endfunction

endpackage

// ===== sv/rtpe_in_stage.sv =====
// ----------------------------------------------------------------------------
// rtpe_in_stage
// Input register: holds one accepted byte item until the parser takes it.
// ----------------------------------------------------------------------------
module rtpe_in_stage import rtpe_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_take,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// ===== sv/rtpe_parse_core.sv =====
// ----------------------------------------------------------------------------
// rtpe_parse_core
// Per-byte operand parser: token collection, name match, separator and
// trailing byte checks, and instruction encoding on a successful verdict.
// ----------------------------------------------------------------------------
module rtpe_parse_core import rtpe_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_fire,
    input  t_item   i_item,
    output logic    o_emit,
    output t_result o_result
);

    t_phase      r_phase;
    t_phase      n_phase;
    logic [31:0] r_tok;
    logic [31:0] n_tok;
    logic [2:0]  r_len;
    logic [2:0]  n_len;
    logic [4:0]  r_dest;
    logic [4:0]  n_dest;
    logic [4:0]  r_src1;
    logic [4:0]  n_src1;
    logic [4:0]  r_rs2;
    logic [4:0]  n_rs2;
    logic [2:0]  r_op;
    logic [2:0]  n_op;

    t_phase      e_phase;
    logic [31:0] e_tok;
    logic [2:0]  e_len;
    logic [7:0]  ch;
    t_lookup     lk;
    logic [31:0] app_tok;
    logic [2:0]  app_len;
    logic        app_bad;
    logic        fail;
    logic        trail;
    logic        ok;
    logic [4:0]  trail_rs2;
    logic [1:0]  ok_status;

    // Line start restarts the parse before the byte is looked at.
    assign ch      = i_item.char_code;
    assign e_phase = i_item.line_start ? PH_TOK1 : r_phase;
    assign e_tok   = i_item.line_start ? '0 : r_tok;
    assign e_len   = i_item.line_start ? '0 : r_len;
    assign lk      = reg_lookup(e_tok);

    always_comb begin
        app_tok = e_tok;
        case (e_len[1:0])
            2'd0:    app_tok[7:0]   = ch;
            2'd1:    app_tok[15:8]  = ch;
            2'd2:    app_tok[23:16] = ch;
            2'd3:    app_tok[31:24] = ch;
            default: app_tok = e_tok;
        endcase
        app_len = e_len + 3'd1;
        // A fifth byte, or a four-byte token other than zero, is too long.
        app_bad = e_len[2] || (app_len == 3'd4 && app_tok != NAME_ZERO);
    end

    always_comb begin
        n_phase   = e_phase;
        n_tok     = e_tok;
        n_len     = e_len;
        n_dest    = r_dest;
        n_src1    = r_src1;
        n_rs2     = r_rs2;
        n_op      = i_item.line_start ? i_item.operation : r_op;
        fail      = 1'b0;
        trail     = 1'b0;
        ok        = 1'b0;
        trail_rs2 = r_rs2;
        ok_status = ST_OK;

        case (e_phase)
            PH_TOK1, PH_TOK2: begin
                if (ch == CH_COMMA) begin
                    if (!lk.hit) begin
                        fail = 1'b1;
                    end else begin
                        if (e_phase == PH_TOK1) begin
                            n_dest  = lk.num;
                            n_phase = PH_GAP1;
                        end else begin
                            n_src1  = lk.num;
                            n_phase = PH_GAP2;
                        end
                        n_tok = '0;
                        n_len = '0;
                    end
                end else if (ch == CH_NUL || ch == CH_NL || ch == CH_EOF || app_bad) begin
                    fail = 1'b1;
                end else begin
                    n_tok = app_tok;
                    n_len = app_len;
                end
            end
            PH_GAP1, PH_GAP2: begin
                if (ch != CH_SPACE) begin
                    fail = 1'b1;
                end else begin
                    n_phase = (e_phase == PH_GAP1) ? PH_TOK2 : PH_TOK3;
                end
            end
            PH_TOK3: begin
                if (ch == CH_NL || ch == CH_SPACE || ch == CH_NUL || ch == CH_SEMI) begin
                    if (!lk.hit) begin
                        fail = 1'b1;
                    end else begin
                        n_rs2     = lk.num;
                        n_len     = '0;
                        n_phase   = PH_TRAIL;
                        trail     = 1'b1;
                        trail_rs2 = lk.num;
                    end
                end else if (app_bad) begin
                    fail = 1'b1;
                end else begin
                    n_tok = app_tok;
                    n_len = app_len;
                end
            end
            PH_TRAIL: begin
                trail = 1'b1;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        if (trail) begin
            if (ch == CH_NL || ch == CH_EOF) begin
                ok = 1'b1;
                ok_status = ST_OK;
            end else if (ch == CH_NUL) begin
                ok = 1'b1;
                ok_status = ST_NUL;
            end else if (ch == CH_SEMI) begin
                ok = 1'b1;
                ok_status = ST_CMT;
            end else if (ch != CH_SPACE) begin
                fail = 1'b1;
            end
        end

        if (fail || ok) begin
            n_phase = PH_IDLE;
        end
    end

    always_comb begin
        o_emit   = i_fire && (fail || ok);
        o_result = '0;
        if (ok) begin
            o_result.status     = ok_status;
            o_result.instr_word = encode_word(n_op, r_dest, r_src1, trail_rs2);
            o_result.dest_reg   = r_dest;
            o_result.src1_reg   = r_src1;
            o_result.src2_reg   = trail_rs2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tok   <= '0;
            r_len   <= '0;
            r_dest  <= '0;
            r_src1  <= '0;
            r_rs2   <= '0;
            r_op    <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_tok   <= n_tok;
            r_len   <= n_len;
            r_dest  <= n_dest;
            r_src1  <= n_src1;
            r_rs2   <= n_rs2;
            r_op    <= n_op;
        end
    end

endmodule

// ===== sv/rtpe_out_stage.sv =====
// ----------------------------------------------------------------------------
// rtpe_out_stage
// Result register: holds one result item until the consumer takes it.
// ----------------------------------------------------------------------------
module rtpe_out_stage import rtpe_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_free,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== sv/r_type_operand_parse_encode_top.sv =====
// ----------------------------------------------------------------------------
// r_type_operand_parse_encode_top
// Parse state updates in a single pass; results wait in the result register.
// Throughput: one byte item per cycle, only while the input register advances.
// The input register advances whenever the result register is free or being taken.
// Reset: synchronous active-low; parser idles until a line start, both stages empty.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module r_type_operand_parse_encode_top import rtpe_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_item   i_item,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    stg_valid;
    t_item   stg_item;
    logic    out_free;
    logic    fire;
    logic    emit;
    t_result core_result;
    logic    res_fail;
    logic    res_ok;

    assign fire = stg_valid && out_free;

    rtpe_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .i_take  (fire),
        .o_valid (stg_valid),
        .o_item  (stg_item)
    );

    rtpe_parse_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (stg_item),
        .o_emit   (emit),
        .o_result (core_result)
    );

    rtpe_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (emit),
        .i_result (core_result),
        .o_free   (out_free),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result)
    );

    assign res_fail = o_valid && (o_result.status == ST_FAIL);
    assign res_ok   = o_valid && (o_result.status != ST_FAIL);

    `AST_NEVER(a_fail_zero, res_fail && (o_result.instr_word != '0 || o_result.dest_reg != '0))
    `AST_IMPLY(a_ok_opcode, res_ok, o_result.instr_word[6:0] == OPC_OP)
    `AST_IMPLY(a_ok_dest, res_ok, o_result.instr_word[11:7] == o_result.dest_reg)
    `AST_IMPLY(a_ok_src2, res_ok, o_result.instr_word[24:20] == o_result.src2_reg)

endmodule
